// ===== design/htc_pkg.sv =====
package htc_pkg;

	// pipeline depth, input register to output register
	localparam int unsigned STAGES = 10;

	// configuration register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_TEMP_COEF_ONE      = 3'd0;
	localparam logic [2:0] REG_TEMP_COEF_TWO      = 3'd1;
	localparam logic [2:0] REG_TEMP_COEF_THREE    = 3'd2;
	localparam logic [2:0] REG_HUM_COEF_ONE       = 3'd3;
	localparam logic [2:0] REG_HUM_COEF_TWO       = 3'd4;
	localparam logic [2:0] REG_HUM_COEF_THREE     = 3'd5;
	localparam logic [2:0] REG_HUM_COEF_FOUR_FIVE = 3'd6;
	localparam logic [2:0] REG_HUM_COEF_SIX       = 3'd7;

	// compensation constants
	localparam logic signed [31:0] HUM_OFFSET = 32'sd76800;
	localparam logic [31:0]        HUM_LIMIT  = 32'd419430400;
	localparam logic signed [31:0] HUM_ROUND  = 32'sd16384;
	localparam logic signed [31:0] HUM_BIAS   = 32'sd2097152;
	localparam logic signed [31:0] HUM_MID    = 32'sd32768;
	localparam logic signed [31:0] HUM_HALF   = 32'sd8192;
	localparam logic signed [31:0] TEMP_ROUND = 32'sd128;

	// fahrenheit offset and reciprocal of 5 (exact floor for values below 2^22)
	localparam logic signed [18:0] FAHR_OFFSET = 19'sd3200;
	localparam logic [19:0]        RECIP_FIVE  = 20'd838861;

	// humidity output ceiling, 100 percent in q7.10
	localparam logic [16:0] HUM_MAX_Q10 = 17'd102400;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} htc_in_t;

	typedef struct packed {
		logic signed [15:0] temp_centi_celsius;
		logic signed [15:0] temp_centi_fahrenheit;
		logic [16:0]        humidity_q10;
		logic signed [31:0] fine_temperature;
	} htc_out_t;

endpackage

// ===== design/humidity_temperature_compensation_top.sv =====
// datapath: a request accepted into s1 moves through s2 to s9 and shows its result in the s10 output register
// throughput: one request per cycle when out_stall is low; ten register stages, at most one multiplier in series each
// stall: out_stall backs up through a per-stage ready chain, so bubbles are squeezed out
// reset: arst_n clears the stage valid bits and all coefficient registers to zero
// payload registers are not reset
module humidity_temperature_compensation_top
	import htc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// sample request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  htc_in_t            in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output htc_out_t           out_data,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// coefficient registers
	logic [15:0] t1_q;
	logic [15:0] t2_q;
	logic [15:0] t3_q;
	logic [7:0]  h1_q;
	logic [15:0] h2_q;
	logic [7:0]  h3_q;
	logic [23:0] h45_q;
	logic [7:0]  h6_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			h45_q <= '0;
			h6_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TEMP_COEF_ONE:      t1_q  <= pwdata[15:0];
				REG_TEMP_COEF_TWO:      t2_q  <= pwdata[15:0];
				REG_TEMP_COEF_THREE:    t3_q  <= pwdata[15:0];
				REG_HUM_COEF_ONE:       h1_q  <= pwdata[7:0];
				REG_HUM_COEF_TWO:       h2_q  <= pwdata[15:0];
				REG_HUM_COEF_THREE:     h3_q  <= pwdata[7:0];
				REG_HUM_COEF_FOUR_FIVE: h45_q <= pwdata[23:0];
				REG_HUM_COEF_SIX:       h6_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (reg_idx)
			REG_TEMP_COEF_ONE:      prdata = {16'b0, t1_q};
			REG_TEMP_COEF_TWO:      prdata = {16'b0, t2_q};
			REG_TEMP_COEF_THREE:    prdata = {16'b0, t3_q};
			REG_HUM_COEF_ONE:       prdata = {24'b0, h1_q};
			REG_HUM_COEF_TWO:       prdata = {16'b0, h2_q};
			REG_HUM_COEF_THREE:     prdata = {24'b0, h3_q};
			REG_HUM_COEF_FOUR_FIVE: prdata = {8'b0, h45_q};
			REG_HUM_COEF_SIX:       prdata = {24'b0, h6_q};
			default:                prdata = '0;
		endcase
	end

	// coefficients widened to the 32-bit datapath
	logic signed [31:0] t1_w, t2_w, t3_w, h1_w, h2_w, h3_w, h5_w, h6_w;
	logic [11:0]        h4_lo;

	assign t1_w  = $signed({16'b0, t1_q});
	assign t2_w  = $signed({{16{t2_q[15]}}, t2_q});
	assign t3_w  = $signed({{16{t3_q[15]}}, t3_q});
	assign h1_w  = $signed({24'b0, h1_q});
	assign h2_w  = $signed({{16{h2_q[15]}}, h2_q});
	assign h3_w  = $signed({24'b0, h3_q});
	assign h4_lo = h45_q[11:0];
	assign h5_w  = $signed({{20{h45_q[23]}}, h45_q[23:12]});
	assign h6_w  = $signed({{24{h6_q[7]}}, h6_q});

	// stage handshake: a stage takes new data when it is empty or the next one moves
	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] adv;
	logic [STAGES:1]   vld_in;

	always_comb begin
		adv[STAGES+1] = !out_stall;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign vld_in = {vld_q[STAGES-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[STAGES];

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7fff;
		end else if (v < -32'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// pipeline registers
	logic [15:0]        adc_h_s1, adc_h_s2, adc_h_s3, adc_h_s4;
	logic signed [31:0] p1_s1, dd_s1;
	logic signed [31:0] var1_s2, m2_s2;
	logic signed [31:0] fine_s3, x_s3;
	logic signed [31:0] fine_s4, tc_s4, hx5_s4, xh6_s4, xh3_s4;
	logic signed [31:0] fine_s5, a_s5, bm_s5;
	logic signed [15:0] tc_s5;
	logic signed [19:0] t9_s5;
	logic signed [31:0] fine_s6, a_s6, cp_s6;
	logic signed [15:0] tc_s6;
	logic               neg_s6;
	logic [18:0]        mag_s6;
	logic signed [31:0] fine_s7, ax_s7;
	logic signed [15:0] tc_s7;
	logic               neg_s7;
	logic [16:0]        q5_s7;
	logic signed [31:0] fine_s8, ax_s8, qq_s8;
	logic signed [15:0] tc_s8, f_s8;
	logic signed [31:0] fine_s9, ax_s9, r_s9;
	logic signed [15:0] tc_s9, f_s9;
	htc_out_t           data_s10;

	// stage combinational values
	logic signed [31:0] c1_a, c1_d;
	logic signed [31:0] c3_sum;
	logic signed [15:0] c5_ts;
	logic signed [31:0] c5_a, c5_u, c5_v;
	logic signed [19:0] c5_tw;
	logic signed [31:0] c6_b;
	logic signed [31:0] c7_c;
	logic [38:0]        c7_prod;
	logic signed [31:0] c8_q;
	logic signed [18:0] c8_f;
	logic signed [31:0] c10_x;
	logic [16:0]        c10_h;

	always_comb begin
		// temperature difference terms
		c1_a = $signed({15'b0, in_data.raw_temperature[19:3]}) - $signed({15'b0, t1_q, 1'b0});
		c1_d = $signed({16'b0, in_data.raw_temperature[19:4]}) - t1_w;
		// fine temperature and humidity offset
		c3_sum = var1_s2 + (m2_s2 >>> 14);
		// saturated celsius
		c5_ts = sat16(tc_s4);
		// humidity first factor, pre-shift
		c5_a = $signed({2'b0, adc_h_s4, 14'b0}) - $signed({h4_lo, 20'b0}) - hx5_s4 + HUM_ROUND;
		c5_u = xh6_s4 >>> 10;
		c5_v = (xh3_s4 >>> 11) + HUM_MID;
		// celsius times 9 on the saturated value, enough to saturate fahrenheit too
		c5_tw = {{4{c5_ts[15]}}, c5_ts} + ({{4{c5_ts[15]}}, c5_ts} <<< 3);
		c6_b = (bm_s5 >>> 10) + HUM_BIAS;
		c7_c = (cp_s6 + HUM_HALF) >>> 14;
		c7_prod = {1'b0, mag_s6} * {19'b0, RECIP_FIVE};
		c8_q = ax_s7 >>> 15;
		// truncating divide: apply the sign to the floored magnitude
		c8_f = (neg_s7 ? -$signed({2'b0, q5_s7}) : $signed({2'b0, q5_s7})) + FAHR_OFFSET;
		// final humidity with clamp to 0..100 percent
		c10_x = ax_s9 - (r_s9 >>> 4);
		if (c10_x[31]) begin
			c10_h = '0;
		end else if ($unsigned(c10_x) > HUM_LIMIT) begin
			c10_h = HUM_MAX_Q10;
		end else begin
			c10_h = c10_x[28:12];
		end
	end

	always_ff @(posedge clk) begin
		// s1: raw products of the temperature terms
		if (adv[1]) begin
			adc_h_s1 <= in_data.raw_humidity;
			p1_s1    <= c1_a * t2_w;
			dd_s1    <= c1_d * c1_d;
		end
		// s2
		if (adv[2]) begin
			adc_h_s2 <= adc_h_s1;
			var1_s2  <= p1_s1 >>> 11;
			m2_s2    <= (dd_s1 >>> 12) * t3_w;
		end
		// s3: fine temperature
		if (adv[3]) begin
			adc_h_s3 <= adc_h_s2;
			fine_s3  <= c3_sum;
			x_s3     <= c3_sum - HUM_OFFSET;
		end
		// s4: celsius and the three humidity products on the offset fine value
		if (adv[4]) begin
			adc_h_s4 <= adc_h_s3;
			fine_s4  <= fine_s3;
			tc_s4    <= (fine_s3 + (fine_s3 <<< 2) + TEMP_ROUND) >>> 8;
			hx5_s4   <= h5_w * x_s3;
			xh6_s4   <= x_s3 * h6_w;
			xh3_s4   <= x_s3 * h3_w;
		end
		// s5
		if (adv[5]) begin
			fine_s5 <= fine_s4;
			a_s5    <= c5_a >>> 15;
			bm_s5   <= c5_u * c5_v;
			tc_s5   <= c5_ts;
			t9_s5   <= c5_tw;
		end
		// s6
		if (adv[6]) begin
			fine_s6 <= fine_s5;
			a_s6    <= a_s5;
			cp_s6   <= c6_b * h2_w;
			tc_s6   <= tc_s5;
			neg_s6  <= t9_s5[19];
			mag_s6  <= t9_s5[19] ? 19'(-t9_s5) : t9_s5[18:0];
		end
		// s7
		if (adv[7]) begin
			fine_s7 <= fine_s6;
			ax_s7   <= a_s6 * c7_c;
			tc_s7   <= tc_s6;
			neg_s7  <= neg_s6;
			q5_s7   <= c7_prod[38:22];
		end
		// s8
		if (adv[8]) begin
			fine_s8 <= fine_s7;
			ax_s8   <= ax_s7;
			qq_s8   <= c8_q * c8_q;
			tc_s8   <= tc_s7;
			f_s8    <= sat16(32'(c8_f));
		end
		// s9
		if (adv[9]) begin
			fine_s9 <= fine_s8;
			ax_s9   <= ax_s8;
			r_s9    <= (qq_s8 >>> 7) * h1_w;
			tc_s9   <= tc_s8;
			f_s9    <= f_s8;
		end
		// s10: output register
		if (adv[10]) begin
			data_s10.temp_centi_celsius    <= tc_s9;
			data_s10.temp_centi_fahrenheit <= f_s9;
			data_s10.humidity_q10          <= c10_h;
			data_s10.fine_temperature      <= fine_s9;
		end
	end

	assign out_data = data_s10;

endmodule

// ===== design/htc_checker.sv =====
module htc_checker
	import htc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input htc_out_t    out_data
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// with the result side free, the request side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("request stalled without downstream stall");

	// humidity never above 100 percent
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.humidity_q10 <= HUM_MAX_Q10)
		else $error("humidity above limit");

	// saturated celsius implies saturated fahrenheit of the same sign
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.temp_centi_celsius == 16'sh7fff)
		|-> out_data.temp_centi_fahrenheit == 16'sh7fff)
		else $error("fahrenheit not saturated high");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.temp_centi_celsius == 16'sh8000)
		|-> out_data.temp_centi_fahrenheit == 16'sh8000)
		else $error("fahrenheit not saturated low");

endmodule

bind humidity_temperature_compensation_top htc_checker u_htc_checker (.*);

// ===== bench/htc_bench_pkg.sv =====
package htc_bench_pkg;

	import htc_pkg::*;

	function automatic logic signed [15:0] clamp_centi(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	class htc_scoreboard;

		// shadow copy of the coefficient registers
		bit [15:0] t1, t2, t3, h2;
		bit [7:0]  h1, h3, h6;
		bit [23:0] h45;

		htc_out_t    expected_q[$];
		int unsigned mismatches;
		int unsigned samples_seen;
		int unsigned results_checked;

		function void write_coef(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_TEMP_COEF_ONE:      t1  = value[15:0];
				REG_TEMP_COEF_TWO:      t2  = value[15:0];
				REG_TEMP_COEF_THREE:    t3  = value[15:0];
				REG_HUM_COEF_ONE:       h1  = value[7:0];
				REG_HUM_COEF_TWO:       h2  = value[15:0];
				REG_HUM_COEF_THREE:     h3  = value[7:0];
				REG_HUM_COEF_FOUR_FIVE: h45 = value[23:0];
				REG_HUM_COEF_SIX:       h6  = value[7:0];
				default: ;
			endcase
		endfunction

		// 32-bit integer compensation, every intermediate wraps but the 64-bit celsius copy and fahrenheit
		function htc_out_t compensate(htc_in_t s);
			int       adc_t, adc_h;
			int       k_t1, k_t2, k_t3, k_h1, k_h2, k_h3, k_h4, k_h5, k_h6;
			int       var1, var2, d, fine, tc, x, a, b, c, q;
			longint   t_full, f;
			htc_out_t r;
			adc_t = int'(s.raw_temperature);
			adc_h = int'(s.raw_humidity);
			k_t1  = int'(t1);
			k_t2  = int'($signed(t2));
			k_t3  = int'($signed(t3));
			k_h1  = int'(h1);
			k_h2  = int'($signed(h2));
			k_h3  = int'(h3);
			k_h4  = int'($signed(h45[11:0]));
			k_h5  = int'($signed(h45[23:12]));
			k_h6  = int'($signed(h6));

			var1   = (((adc_t >>> 3) - (k_t1 <<< 1)) * k_t2) >>> 11;
			d      = (adc_t >>> 4) - k_t1;
			var2   = (((d * d) >>> 12) * k_t3) >>> 14;
			fine   = var1 + var2;
			tc     = (fine * 5 + TEMP_ROUND) >>> 8;
			t_full = longint'(tc);
			f      = (t_full * 64'sd9) / 64'sd5 + 64'sd3200;

			x = fine - HUM_OFFSET;
			a = ((adc_h <<< 14) - (k_h4 <<< 20) - k_h5 * x + HUM_ROUND) >>> 15;
			b = ((((x * k_h6) >>> 10) * (((x * k_h3) >>> 11) + HUM_MID)) >>> 10) + HUM_BIAS;
			c = (b * k_h2 + HUM_HALF) >>> 14;
			x = a * c;
			q = x >>> 15;
			x = x - ((((q * q) >>> 7) * k_h1) >>> 4);
			if (x < 0)
				x = 0;
			if (x > int'(HUM_LIMIT))
				x = int'(HUM_LIMIT);

			r.temp_centi_celsius    = clamp_centi(t_full);
			r.temp_centi_fahrenheit = clamp_centi(f);
			r.humidity_q10          = 17'(x >>> 12);
			r.fine_temperature      = fine;
			return r;
		endfunction

		function void note_request(htc_in_t s);
			expected_q.push_back(compensate(s));
			samples_seen++;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// one line per mismatch
		task flag_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(htc_out_t got);
			htc_out_t want;
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("result %h with none outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (got.temp_centi_celsius !== want.temp_centi_celsius)
				flag_mismatch($sformatf("celsius got %0d want %0d",
					got.temp_centi_celsius, want.temp_centi_celsius));
			if (got.temp_centi_fahrenheit !== want.temp_centi_fahrenheit)
				flag_mismatch($sformatf("fahrenheit got %0d want %0d",
					got.temp_centi_fahrenheit, want.temp_centi_fahrenheit));
			if (got.humidity_q10 !== want.humidity_q10)
				flag_mismatch($sformatf("humidity got %0d want %0d",
					got.humidity_q10, want.humidity_q10));
			if (got.fine_temperature !== want.fine_temperature)
				flag_mismatch($sformatf("fine temperature got %0d want %0d",
					got.fine_temperature, want.fine_temperature));
		endtask

		task check_drained();
			if (expected_q.size() != 0)
				flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
		endtask

	endclass

endpackage

// ===== bench/tb_humidity_temperature_compensation_top.sv =====
module tb_humidity_temperature_compensation_top;

	timeunit 1ns;
	timeprecision 1ps;

	import htc_pkg::*;
	import htc_bench_pkg::*;

	typedef bit bool_t;

	// cycles with no handshake on any port before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned RANDOM_PHASES  = 8;
	localparam int unsigned PHASE_ITEMS    = 175;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	htc_in_t     in_data  = '0;
	logic        out_stall = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;

	logic        in_stall;
	logic        out_valid;
	htc_out_t    out_data;
	logic [31:0] prdata;
	logic        pready;

	htc_scoreboard sb = new();

	// percent chance of a stall burst per cycle and of a gap per request
	int unsigned idle_pct      = 0;
	int unsigned settings_used = 0;

	// register values for the next programming pass, indexed by register
	logic [31:0] coef_plan [8];

	// corner readings: extremes, alternating bits, a typical room reading
	htc_in_t corner_samples [10] = '{
		'{raw_temperature: 20'h00000, raw_humidity: 16'h0000},
		'{raw_temperature: 20'hfffff, raw_humidity: 16'hffff},
		'{raw_temperature: 20'd519888, raw_humidity: 16'd30000},
		'{raw_temperature: 20'h80000, raw_humidity: 16'h8000},
		'{raw_temperature: 20'hfffff, raw_humidity: 16'h0000},
		'{raw_temperature: 20'h00000, raw_humidity: 16'hffff},
		'{raw_temperature: 20'h55555, raw_humidity: 16'haaaa},
		'{raw_temperature: 20'haaaaa, raw_humidity: 16'h5555},
		'{raw_temperature: 20'd415148, raw_humidity: 16'h0000},
		'{raw_temperature: 20'd415148, raw_humidity: 16'hffff}
	};

	always #1 clk = ~clk;

	humidity_temperature_compensation_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// both channels sampled at the edge, before any driver update lands
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// result side back-pressure: random bursts of stalled cycles
	initial begin
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// hang detector: ends the run when no port moves for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	function automatic htc_in_t pack_sample(int unsigned t, int unsigned h);
		htc_in_t s;
		s.raw_temperature = t[19:0];
		s.raw_humidity    = h[15:0];
		return s;
	endfunction

	// one register write: setup cycle, then access until pready
	// psel is left high so back-to-back writes never toggle it within a step
	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_coef(idx, value);
	endtask

	// writes every register from coef_plan; only called with the pipe empty
	task automatic program_coefs();
		for (int i = 0; i < 8; i++)
			apb_write(3'(i), coef_plan[i]);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	// one request, with an optional random gap ahead of it
	task automatic send_sample(htc_in_t s);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait for every outstanding result
	// the first edge lets the monitor log the last accepted request
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic send_corners(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_sample(corner_samples[i]);
		drain_results();
	endtask

	// coefficients near a typical calibrated part, so humidity lands in range
	task automatic plan_typical_coefs();
		int h4, h5;
		h4 = $urandom_range(250, 400);
		h5 = $urandom_range(0, 100);
		coef_plan[REG_TEMP_COEF_ONE]      = $urandom_range(26000, 29000);
		coef_plan[REG_TEMP_COEF_TWO]      = $urandom_range(25000, 28000);
		coef_plan[REG_TEMP_COEF_THREE]    = 32'(-int'($urandom_range(500, 1500)));
		coef_plan[REG_HUM_COEF_ONE]       = $urandom_range(0, 255);
		coef_plan[REG_HUM_COEF_TWO]       = $urandom_range(300, 420);
		coef_plan[REG_HUM_COEF_THREE]     = $urandom_range(0, 255);
		coef_plan[REG_HUM_COEF_FOUR_FIVE] = {8'h00, 12'(h5), 12'(h4)};
		coef_plan[REG_HUM_COEF_SIX]       = 32'(int'($urandom_range(0, 80)) - 20);
	endtask

	// full 32-bit junk: upper bits must be dropped, often wraps intermediates
	task automatic plan_random_coefs();
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 7) == 0)
				coef_plan[i] = $urandom_range(0, 1) ? '1 : '0;
			else
				coef_plan[i] = $urandom();
		end
	endtask

	initial begin : stimulus
		htc_in_t s;
		bool_t   typical;
		// reset once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: everything zero
		send_corners(2);

		// typical calibration, light idling
		idle_pct = 10;
		coef_plan[REG_TEMP_COEF_ONE]      = 32'd27504;
		coef_plan[REG_TEMP_COEF_TWO]      = 32'd26435;
		coef_plan[REG_TEMP_COEF_THREE]    = 32'hffff_fc18;
		coef_plan[REG_HUM_COEF_ONE]       = 32'd75;
		coef_plan[REG_HUM_COEF_TWO]       = 32'd362;
		coef_plan[REG_HUM_COEF_THREE]     = 32'd0;
		coef_plan[REG_HUM_COEF_FOUR_FIVE] = {8'h00, 12'd50, 12'd313};
		coef_plan[REG_HUM_COEF_SIX]       = 32'd30;
		program_coefs();
		send_corners(10);

		// largest positive coefficients: temperature saturates, products wrap
		coef_plan[REG_TEMP_COEF_ONE]      = 32'h0000_0000;
		coef_plan[REG_TEMP_COEF_TWO]      = 32'h0000_7fff;
		coef_plan[REG_TEMP_COEF_THREE]    = 32'h0000_7fff;
		coef_plan[REG_HUM_COEF_ONE]       = 32'h0000_00ff;
		coef_plan[REG_HUM_COEF_TWO]       = 32'h0000_7fff;
		coef_plan[REG_HUM_COEF_THREE]     = 32'h0000_00ff;
		coef_plan[REG_HUM_COEF_FOUR_FIVE] = 32'h007f_f7ff;
		coef_plan[REG_HUM_COEF_SIX]       = 32'h0000_007f;
		program_coefs();
		send_corners(6);

		// most negative signed coefficients, H4 and H5 both at -2048
		coef_plan[REG_TEMP_COEF_ONE]      = 32'h0000_ffff;
		coef_plan[REG_TEMP_COEF_TWO]      = 32'h0000_8000;
		coef_plan[REG_TEMP_COEF_THREE]    = 32'h0000_8000;
		coef_plan[REG_HUM_COEF_ONE]       = 32'h0000_00ff;
		coef_plan[REG_HUM_COEF_TWO]       = 32'h0000_8000;
		coef_plan[REG_HUM_COEF_THREE]     = 32'h0000_00ff;
		coef_plan[REG_HUM_COEF_FOUR_FIVE] = 32'h0080_0800;
		coef_plan[REG_HUM_COEF_SIX]       = 32'h0000_0080;
		program_coefs();
		send_corners(6);

		// random phases: typical and junk coefficients alternate,
		// idling varies per phase and the last phase runs flat out
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0, 5:    idle_pct = 10;
				1:       idle_pct = 25;
				2:       idle_pct = 0;
				3:       idle_pct = 5;
				4:       idle_pct = 40;
				6:       idle_pct = 20;
				default: idle_pct = 0;
			endcase
			typical = (p % 2 == 0);
			if (typical)
				plan_typical_coefs();
			else
				plan_random_coefs();
			program_coefs();
			for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
				// mostly realistic readings under typical coefficients
				if (typical && $urandom_range(0, 9) < 7)
					s = pack_sample($urandom_range(400000, 600000),
						$urandom_range(20000, 45000));
				else
					s = pack_sample($urandom_range(0, 20'hfffff),
						$urandom_range(0, 16'hffff));
				send_sample(s);
			end
			drain_results();
		end

		// settle past the pipeline depth so a stray extra result is seen
		repeat (STAGES + 4) @(posedge clk);
		sb.check_drained();

		$display("checked %0d results from %0d samples over %0d coefficient settings",
			sb.results_checked, sb.samples_seen, settings_used);
		$display("covered corner readings, saturating and wrapping coefficients, two-sided stalls");
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
